@@ sv/uer_pkg.sv @@
// Shared constants, types and the distance conversion for the echo ranger.
package uer_pkg;

    // Echo timer width and derived widths for the distance conversion
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned PROD_W    = COUNT_W + 6;
    localparam int unsigned DIV_SHIFT = PROD_W + 10;
    localparam int unsigned MUL_W     = 2 * PROD_W + 1;
    localparam int unsigned QUOT_W    = PROD_W - 9;

    localparam int unsigned MS_W   = 16;
    localparam int unsigned TICK_W = 8;
    localparam int unsigned DIST_W = 12;

    localparam logic [MS_W-1:0]   MS_MAX        = 16'hFFFF;
    localparam logic [MS_W-1:0]   MIN_INT_RST   = 16'd100;
    localparam logic [TICK_W-1:0] TRIG_TICK_RST = 8'd5;
    localparam int unsigned       DIST_MAX      = 4095;
    localparam int unsigned       SOUND_NUM     = 34;
    localparam int unsigned       SOUND_DEN     = 1000;

    // ceil(2^DIV_SHIFT / 1000): exact floor division for all PROD_W-bit dividends
    localparam longint unsigned DIV_RECIP =
        ((64'd1 << DIV_SHIFT) + SOUND_DEN - 1) / SOUND_DEN;

    // Configuration register indexes
    localparam logic CFG_MIN_INTERVAL = 1'b0;
    localparam logic CFG_TRIG_TICKS   = 1'b1;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef struct packed {
        logic echo_level;
        logic ms_strobe;
        logic trigger_request;
    } t_in_item;

    typedef struct packed {
        logic              capture;
        logic [DIST_W-1:0] distance;
    } t_echo_res;

    typedef struct packed {
        logic trigger_level;
        logic ready_res;
    } t_trig_res;

    // distance = floor(34 * count / 1000), saturated to DIST_W bits
    function automatic logic [DIST_W-1:0] f_distance(input logic [COUNT_W-1:0] count);
        logic [PROD_W-1:0] prod_x;
        logic [MUL_W-1:0]  prod_q;
        logic [QUOT_W-1:0] quot;
        prod_x = PROD_W'(count) * PROD_W'(SOUND_NUM);
        prod_q = MUL_W'(prod_x) * MUL_W'(DIV_RECIP);
        quot   = prod_q[MUL_W-1:DIV_SHIFT];
        if (MUL_W'(quot) > MUL_W'(DIST_MAX)) begin
            return DIST_W'(DIST_MAX);
        end
        return DIST_W'(quot);
    endfunction

endpackage

@@ sv/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: stream stages, config registers, checks.
//
// One input transfer on the s_axis channel is one 2 us tick of the echo timer:
// echo pin level, millisecond strobe and trigger request. Each tick yields exactly
// one result transfer on m_axis: trigger pin level, last distance in cm, a strobe
// for a freshly captured distance, and the ready flag.
// A transfer is registered into an input stage; the tick is then evaluated against
// the ranging state and loaded into the result register, which offers it on m_axis.
// Throughput is one tick per cycle: the input stage drains whenever the result
// register is empty or being taken.
// When m_axis_tready is low the result register holds, the input stage holds its
// tick and s_axis_tready drops once both are full; no tick is lost or repeated,
// since ranging state advances only when a tick moves into the result register.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) are registered; the user
// must make them while the channel is idle, as the block does not enforce it: index 0
// is the minimum trigger interval in ms, index 1 the trigger pulse width in ticks.
// Synchronous reset empties both stages, restores the configuration defaults
// (100 ms, 5 ticks), sets ready and clears the timer, distance and pulse state.
module ultrasonic_echo_ranger
    import uer_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [MS_W-1:0]        i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] echo_level, [1] ms_strobe, [2] trigger_request, [7:3] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] trigger_level, [12:1] distance_cm, [13] distance_valid, [14] ready_res,
    // [15] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                   r_in_valid;
    t_in_item               r_in;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [MS_W-1:0]        r_min_interval;
    logic [TICK_W-1:0]      r_trig_ticks;
    logic                   w_adv;
    logic                   w_in_take;
    t_echo_res              w_echo;
    t_trig_res              w_trig;
    logic [OUT_TDATA_W-1:0] w_result;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval <= MIN_INT_RST;
            r_trig_ticks   <= TRIG_TICK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_wdata;
                CFG_TRIG_TICKS:   r_trig_ticks   <= i_cfg_wdata[TICK_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in.echo_level      <= s_axis_tdata[0];
            r_in.ms_strobe       <= s_axis_tdata[1];
            r_in.trigger_request <= s_axis_tdata[2];
        end
    end

    uer_echo_timer u_echo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_echo  (r_in.echo_level),
        .o_res   (w_echo)
    );

    uer_trigger u_trig (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_ms_strobe    (r_in.ms_strobe),
        .i_request      (r_in.trigger_request),
        .i_capture      (w_echo.capture),
        .i_min_interval (r_min_interval),
        .i_trig_ticks   (r_trig_ticks),
        .o_res          (w_trig)
    );

    assign w_result = {1'b0, w_trig.ready_res, w_echo.capture, w_echo.distance,
                       w_trig.trigger_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A captured distance always comes with ready set
    a_capture_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13]) |-> m_axis_tdata[14])
        else $error("distance captured without ready");

    // Conversion never exceeds the range of the timer
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[12:1] <= DIST_W'(f_distance('1))))
        else $error("distance out of range");

    // A tick held in the input stage stays there until the result side has room
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !m_axis_tready) |=> r_in_valid)
        else $error("input stage dropped a tick");

    // Each result the stage loads came from a held tick
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid))
        else $error("result appeared without a tick");

endmodule

@@ sv/uer_echo_timer.sv @@
// Echo edge detection, echo pulse timer and distance capture.
module uer_echo_timer
    import uer_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_echo,
    output t_echo_res o_res
);

    logic               r_echo_prev, n_echo_prev;
    logic               r_rise_seen, n_rise_seen;
    logic               r_running,   n_running;
    logic [COUNT_W-1:0] r_count,     n_count;
    logic [DIST_W-1:0]  r_dist,      n_dist;
    logic               w_capture;
    logic [COUNT_W-1:0] w_count_inc;

    always_comb begin
        w_count_inc = r_running ? r_count + COUNT_W'(1) : r_count;
        n_echo_prev = i_echo;
        n_rise_seen = r_rise_seen;
        n_running   = r_running;
        n_count     = w_count_inc;
        n_dist      = r_dist;
        w_capture   = 1'b0;
        if (i_echo && !r_echo_prev) begin
            // rising edge restarts the timer from zero
            n_count     = '0;
            n_rise_seen = 1'b1;
            n_running   = 1'b1;
        end else if (!i_echo && r_echo_prev) begin
            n_running = 1'b0;
            if (r_rise_seen) begin
                n_dist    = f_distance(w_count_inc);
                w_capture = 1'b1;
            end
            n_rise_seen = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_prev <= 1'b0;
            r_rise_seen <= 1'b0;
            r_running   <= 1'b0;
            r_count     <= '0;
            r_dist      <= '0;
        end else if (i_adv) begin
            r_echo_prev <= n_echo_prev;
            r_rise_seen <= n_rise_seen;
            r_running   <= n_running;
            r_count     <= n_count;
            r_dist      <= n_dist;
        end
    end

    assign o_res.capture  = w_capture;
    assign o_res.distance = n_dist;

endmodule

@@ sv/uer_trigger.sv @@
// Trigger admission, millisecond interval counter, pulse timer and ready flag.
module uer_trigger
    import uer_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_ms_strobe,
    input  logic              i_request,
    input  logic              i_capture,
    input  logic [MS_W-1:0]   i_min_interval,
    input  logic [TICK_W-1:0] i_trig_ticks,
    output t_trig_res         o_res
);

    logic [MS_W-1:0]   r_ms,    n_ms;
    logic [TICK_W-1:0] r_pulse, n_pulse;
    logic              r_ready, n_ready;
    logic              w_accept;
    logic [TICK_W-1:0] w_pulse_now;
    logic              w_trig;

    always_comb begin
        w_accept = i_request && r_ready && (r_ms > i_min_interval);
        if (w_accept) begin
            n_ms = '0;
        end else if (i_ms_strobe && (r_ms != MS_MAX)) begin
            n_ms = r_ms + MS_W'(1);
        end else begin
            n_ms = r_ms;
        end
        w_pulse_now = w_accept ? i_trig_ticks : r_pulse;
        w_trig      = (w_pulse_now != '0);
        n_pulse     = w_trig ? w_pulse_now - TICK_W'(1) : '0;
        // capture wins over a trigger in the same tick
        n_ready     = i_capture ? 1'b1 : (w_accept ? 1'b0 : r_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms    <= '0;
            r_pulse <= '0;
            r_ready <= 1'b1;
        end else if (i_adv) begin
            r_ms    <= n_ms;
            r_pulse <= n_pulse;
            r_ready <= n_ready;
        end
    end

    assign o_res.trigger_level = w_trig;
    assign o_res.ready_res     = n_ready;

endmodule
